### rtl/rcfe_pkg.sv
package rcfe_pkg;

	// Default configuration of the block.
	localparam int DEF_COORD_BITS   = 32;
	localparam int DEF_FRAC_BITS    = 16;
	localparam int DEF_CELL_ID_BITS = 16;

	// The multiplier consumes one operand in slices of this many bits.
	localparam int CHUNK_BITS = 16;

	// Configuration register map.
	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RAY_DIR_X    = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RAY_DIR_Y    = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RAY_DIR_Z    = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_DISTANCE = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic item_load;
		logic mac_start;
		logic div_start;
		logic best_update;
		logic result_load;
	} rcfe_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic mac_done;
		logic div_needed;
		logic div_done;
		logic last_face;
		logic out_full;
	} rcfe_sts_t;

endpackage

### rtl/rcfe_mac.sv
module rcfe_mac #(
	parameter int COORD_BITS = rcfe_pkg::DEF_COORD_BITS,
	localparam int ACC_W = 2 * COORD_BITS + 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [COORD_BITS-1:0] ray_x,
	input  logic signed [COORD_BITS-1:0] ray_y,
	input  logic signed [COORD_BITS-1:0] ray_z,
	input  logic signed [COORD_BITS-1:0] dir_x,
	input  logic signed [COORD_BITS-1:0] dir_y,
	input  logic signed [COORD_BITS-1:0] dir_z,
	input  logic signed [COORD_BITS-1:0] off_x,
	input  logic signed [COORD_BITS-1:0] off_y,
	input  logic signed [COORD_BITS-1:0] off_z,
	output logic signed [ACC_W-1:0]      num,
	output logic signed [ACC_W-1:0]      den,
	output logic                         done
);

	localparam int CB     = rcfe_pkg::CHUNK_BITS;
	localparam int NCH    = (COORD_BITS + CB - 1) / CB;
	localparam int CIDX_W = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int PROD_W = COORD_BITS + 1 + CB;
	localparam logic [CIDX_W-1:0] CHUNK_LAST = CIDX_W'(NCH - 1);
	localparam logic [2:0] TERM_LAST = 3'd5;

	// Terms run numerator x, denominator x, numerator y, ... ; bit 0 picks the sum.
	logic [2:0]              term_q;
	logic [CIDX_W-1:0]       chunk_q;
	logic                    run_q;
	logic signed [COORD_BITS-1:0] dir_a, off_a, ray_a;
	logic signed [COORD_BITS+1:0] a_num, a_sel, a_neg;
	logic signed [COORD_BITS:0]   d_ext, d_neg;
	logic [COORD_BITS:0]     mag_a;
	logic [COORD_BITS-1:0]   mag_b;
	logic [NCH*CB-1:0]       mag_b_pad;
	logic [CB-1:0]           slice;
	logic [PROD_W-1:0]       prod;
	logic                    issue_last;

	logic [PROD_W-1:0]       prod_s1;
	logic                    neg_s1, den_s1, valid_s1, last_s1;
	logic [CIDX_W-1:0]       chunk_s1;
	logic signed [ACC_W-1:0] shifted, addend;
	logic signed [ACC_W-1:0] num_q, den_q;
	logic                    done_q;

	always_comb begin
		case (term_q[2:1])
			2'd1: begin
				dir_a = dir_y;
				off_a = off_y;
				ray_a = ray_y;
			end
			2'd2: begin
				dir_a = dir_z;
				off_a = off_z;
				ray_a = ray_z;
			end
			default: begin
				dir_a = dir_x;
				off_a = off_x;
				ray_a = ray_x;
			end
		endcase
	end

	assign a_num = {off_a[COORD_BITS-1], off_a, 1'b0} + {{2{dir_a[COORD_BITS-1]}}, dir_a};
	assign a_sel = term_q[0] ? {{2{ray_a[COORD_BITS-1]}}, ray_a} : a_num;
	assign a_neg = -a_sel;
	assign mag_a = a_sel[COORD_BITS+1] ? a_neg[COORD_BITS:0] : a_sel[COORD_BITS:0];
	assign d_ext = {dir_a[COORD_BITS-1], dir_a};
	assign d_neg = -d_ext;
	assign mag_b = dir_a[COORD_BITS-1] ? d_neg[COORD_BITS-1:0] : d_ext[COORD_BITS-1:0];
	assign mag_b_pad = (NCH*CB)'(mag_b);
	assign slice = mag_b_pad[chunk_q*CB +: CB];
	assign prod = PROD_W'(mag_a) * PROD_W'(slice);
	assign issue_last = run_q && (term_q == TERM_LAST) && (chunk_q == CHUNK_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			term_q   <= '0;
			chunk_q  <= '0;
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= run_q;
			last_s1  <= issue_last;
			done_q   <= valid_s1 && last_s1;
			if (start) begin
				run_q   <= 1'b1;
				term_q  <= '0;
				chunk_q <= '0;
			end else if (run_q) begin
				if (chunk_q == CHUNK_LAST) begin
					chunk_q <= '0;
					if (term_q == TERM_LAST) begin
						run_q <= 1'b0;
					end else begin
						term_q <= term_q + 3'd1;
					end
				end else begin
					chunk_q <= chunk_q + CIDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= prod;
		neg_s1   <= a_sel[COORD_BITS+1] ^ dir_a[COORD_BITS-1];
		den_s1   <= term_q[0];
		chunk_s1 <= chunk_q;
	end

	assign shifted = ACC_W'(prod_s1) << (chunk_s1 * CB);
	assign addend  = neg_s1 ? -shifted : shifted;

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= '0;
			den_q <= '0;
		end else if (valid_s1) begin
			if (den_s1) begin
				den_q <= den_q + addend;
			end else begin
				num_q <= num_q + addend;
			end
		end
	end

	assign num  = num_q;
	assign den  = den_q;
	assign done = done_q;

endmodule

### rtl/rcfe_div.sv
module rcfe_div #(
	parameter int COORD_BITS = rcfe_pkg::DEF_COORD_BITS,
	parameter int FRAC_BITS  = rcfe_pkg::DEF_FRAC_BITS,
	localparam int ACC_W = 2 * COORD_BITS + 3
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] num,
	input  logic signed [ACC_W-1:0] den,
	output logic [COORD_BITS-2:0]   quotient,
	output logic                    done
);

	localparam int W_A   = 3 * COORD_BITS + 3;
	localparam int W_B   = ACC_W + FRAC_BITS;
	localparam int W     = (W_A > W_B) ? W_A : W_B;
	localparam int CNT_W = $clog2(COORD_BITS + 1);

	logic [ACC_W-1:0]      mag_n, mag_d;
	logic [W-1:0]          rem_q, dvs_q;
	logic [W:0]            diff;
	logic                  ge;
	logic [COORD_BITS-1:0] q_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q, done_q;

	assign mag_n = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
	assign mag_d = den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);

	// Restoring division, one quotient bit per cycle, most significant first.
	assign diff = {1'b0, rem_q} - {1'b0, dvs_q};
	assign ge   = !diff[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(COORD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= W'(mag_n) << FRAC_BITS;
			dvs_q <= W'(mag_d) << COORD_BITS;
			q_q   <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= diff[W-1:0];
			end
			dvs_q <= dvs_q >> 1;
			q_q   <= {q_q[COORD_BITS-2:0], ge};
		end
	end

	// A set top bit means the quotient does not fit and saturates.
	assign quotient = q_q[COORD_BITS-1] ? '1 : q_q[COORD_BITS-2:0];
	assign done     = done_q;

endmodule

### rtl/rcfe_dpath.sv
module rcfe_dpath #(
	parameter int COORD_BITS   = rcfe_pkg::DEF_COORD_BITS,
	parameter int FRAC_BITS    = rcfe_pkg::DEF_FRAC_BITS,
	parameter int CELL_ID_BITS = rcfe_pkg::DEF_CELL_ID_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rcfe_pkg::rcfe_cmd_t                 cmd,
	output rcfe_pkg::rcfe_sts_t                 sts,
	input  logic                                cfg_wr_en,
	input  logic [rcfe_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]               cfg_data,
	input  logic signed [COORD_BITS-1:0]        face_dir_x,
	input  logic signed [COORD_BITS-1:0]        face_dir_y,
	input  logic signed [COORD_BITS-1:0]        face_dir_z,
	input  logic signed [COORD_BITS-1:0]        centre_offset_x,
	input  logic signed [COORD_BITS-1:0]        centre_offset_y,
	input  logic signed [COORD_BITS-1:0]        centre_offset_z,
	input  logic [CELL_ID_BITS-1:0]             neighbour_id,
	input  logic [COORD_BITS-2:0]               start_bound,
	input  logic [CELL_ID_BITS-1:0]             current_cell,
	input  logic                                first_face,
	input  logic                                last_face,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [COORD_BITS-2:0]               exit_distance,
	output logic [CELL_ID_BITS-1:0]             next_cell,
	output logic                                face_found
);

	localparam int ACC_W = 2 * COORD_BITS + 3;
	localparam logic [COORD_BITS-1:0] RAY_Z_RESET = COORD_BITS'(1) << FRAC_BITS;

	logic signed [COORD_BITS-1:0] ray_x_q, ray_y_q, ray_z_q;
	logic [COORD_BITS-2:0]        min_dist_q;
	logic signed [COORD_BITS-1:0] dir_x_q, dir_y_q, dir_z_q;
	logic signed [COORD_BITS-1:0] off_x_q, off_y_q, off_z_q;
	logic [CELL_ID_BITS-1:0]      nb_id_q;
	logic                         last_q;
	logic [COORD_BITS-2:0]        best_dist_q;
	logic [CELL_ID_BITS-1:0]      best_cell_q, leaving_cell_q;
	logic                         found_q;
	logic                         out_valid_q;
	logic [COORD_BITS-2:0]        exit_dist_q;
	logic [CELL_ID_BITS-1:0]      next_cell_q;
	logic                         face_found_q;

	logic signed [ACC_W-1:0]      num, den;
	logic                         mac_done, div_done;
	logic [COORD_BITS-2:0]        quotient;
	logic                         take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray_x_q    <= '0;
			ray_y_q    <= '0;
			ray_z_q    <= RAY_Z_RESET;
			min_dist_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				rcfe_pkg::REG_RAY_DIR_X:    ray_x_q    <= cfg_data;
				rcfe_pkg::REG_RAY_DIR_Y:    ray_y_q    <= cfg_data;
				rcfe_pkg::REG_RAY_DIR_Z:    ray_z_q    <= cfg_data;
				rcfe_pkg::REG_MIN_DISTANCE: min_dist_q <= cfg_data[COORD_BITS-2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			dir_x_q <= face_dir_x;
			dir_y_q <= face_dir_y;
			dir_z_q <= face_dir_z;
			off_x_q <= centre_offset_x;
			off_y_q <= centre_offset_y;
			off_z_q <= centre_offset_z;
			nb_id_q <= neighbour_id;
			last_q  <= last_face;
		end
	end

	rcfe_mac #(
		.COORD_BITS(COORD_BITS)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mac_start),
		.ray_x (ray_x_q),
		.ray_y (ray_y_q),
		.ray_z (ray_z_q),
		.dir_x (dir_x_q),
		.dir_y (dir_y_q),
		.dir_z (dir_z_q),
		.off_x (off_x_q),
		.off_y (off_y_q),
		.off_z (off_z_q),
		.num   (num),
		.den   (den),
		.done  (mac_done)
	);

	rcfe_div #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.num     (num),
		.den     (den),
		.quotient(quotient),
		.done    (div_done)
	);

	assign take = (quotient < best_dist_q) && (quotient > min_dist_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_dist_q    <= '0;
			best_cell_q    <= '0;
			leaving_cell_q <= '0;
			found_q        <= 1'b0;
		end else if (cmd.item_load && first_face) begin
			best_dist_q    <= start_bound;
			leaving_cell_q <= current_cell;
			found_q        <= 1'b0;
		end else if (cmd.best_update && take) begin
			best_dist_q <= quotient;
			best_cell_q <= nb_id_q;
			found_q     <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.result_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			exit_dist_q  <= best_dist_q;
			next_cell_q  <= found_q ? best_cell_q : leaving_cell_q;
			face_found_q <= found_q;
		end
	end

	always_comb begin
		sts.mac_done   = mac_done;
		sts.div_needed = (num != '0) && (den != '0) && (num[ACC_W-1] == den[ACC_W-1]);
		sts.div_done   = div_done;
		sts.last_face  = last_q;
		sts.out_full   = out_valid_q && !out_ready;
	end

	assign out_valid     = out_valid_q;
	assign exit_distance = exit_dist_q;
	assign next_cell     = next_cell_q;
	assign face_found    = face_found_q;

	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result_load |-> !sts.out_full)
		else $error("result loaded while the output register still holds one");

	a_found_only_by_update: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q && !$past(found_q)) |-> $past(cmd.best_update))
		else $error("found flag set without a best-distance update");

	a_result_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q)) |-> $past(cmd.result_load && last_q))
		else $error("result produced for a face that does not close its run");

	a_best_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.best_update && take) |=> (best_dist_q < $past(best_dist_q)))
		else $error("best distance did not decrease on an accepted face");

endmodule

### rtl/rcfe_ctrl.sv
module rcfe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output rcfe_pkg::rcfe_cmd_t cmd,
	input  rcfe_pkg::rcfe_sts_t sts
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MAC_GO = 3'd1;
	localparam logic [2:0] ST_MAC    = 3'd2;
	localparam logic [2:0] ST_CHECK  = 3'd3;
	localparam logic [2:0] ST_DIV    = 3'd4;
	localparam logic [2:0] ST_UPDATE = 3'd5;
	localparam logic [2:0] ST_EMIT   = 3'd6;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d         = state_q;
		cmd.item_load   = 1'b0;
		cmd.mac_start   = 1'b0;
		cmd.div_start   = 1'b0;
		cmd.best_update = 1'b0;
		cmd.result_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.item_load = 1'b1;
					state_d       = ST_MAC_GO;
				end
			end
			ST_MAC_GO: begin
				cmd.mac_start = 1'b1;
				state_d       = ST_MAC;
			end
			ST_MAC: begin
				if (sts.mac_done) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.div_needed) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.best_update = 1'b1;
				state_d         = ST_EMIT;
			end
			ST_EMIT: begin
				if (!sts.last_face) begin
					state_d = ST_IDLE;
				end else if (!sts.out_full) begin
					cmd.result_load = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

endmodule

### rtl/ray_cell_face_exit_distance_unit.sv
// Ray exit distance from one cell of a Voronoi mesh. Each input transaction
// carries one face of the cell: the vector to the neighbour centre, the cell
// centre minus the ray position, the neighbour id, and first/last markers of
// the cell's run of faces. The block computes the distance along the
// configured ray direction to the face plane, halfway to the neighbour, as
// ((offset + dir/2) . dir) / (ray . dir) in signed fixed point with
// FRAC_BITS fraction bits, truncated toward zero and saturated. Over a run it
// keeps the smallest distance that is above min_distance and below the bound,
// which starts at start_bound on the first face. The last face of a run
// produces one output transaction: the distance, the neighbour across the
// nearest face (or the cell being left when no face qualified), and a found
// flag. The block takes a new face only once it is through with the last
// one; a face whose plane lies behind the ray, parallel to it or through
// the ray position skips the divider. The work is done by the shared
// multiplier, which forms the six dot-product terms one 16-bit slice per
// cycle, and by the restoring divider, which retires one quotient bit per
// cycle. A finished result waits in an output register, so the next face
// is taken while the downstream side stalls; only a second result finding
// that register full holds the block. Configuration writes take effect at
// once and are meant for times when no face is in flight.
module ray_cell_face_exit_distance_unit #(
	parameter int COORD_BITS   = rcfe_pkg::DEF_COORD_BITS,
	parameter int FRAC_BITS    = rcfe_pkg::DEF_FRAC_BITS,
	parameter int CELL_ID_BITS = rcfe_pkg::DEF_CELL_ID_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port.
	input  logic                                cfg_wr_en,
	input  logic [rcfe_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]               cfg_data,
	// Face input channel.
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [COORD_BITS-1:0]        face_dir_x,
	input  logic signed [COORD_BITS-1:0]        face_dir_y,
	input  logic signed [COORD_BITS-1:0]        face_dir_z,
	input  logic signed [COORD_BITS-1:0]        centre_offset_x,
	input  logic signed [COORD_BITS-1:0]        centre_offset_y,
	input  logic signed [COORD_BITS-1:0]        centre_offset_z,
	input  logic [CELL_ID_BITS-1:0]             neighbour_id,
	input  logic [COORD_BITS-2:0]               start_bound,
	input  logic [CELL_ID_BITS-1:0]             current_cell,
	input  logic                                first_face,
	input  logic                                last_face,
	// Result output channel.
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [COORD_BITS-2:0]               exit_distance,
	output logic [CELL_ID_BITS-1:0]             next_cell,
	output logic                                face_found
);

	// The controller sequences one face at a time through the multiplier,
	// the optional division, the best-distance update and the result load.
	rcfe_pkg::rcfe_cmd_t cmd;
	rcfe_pkg::rcfe_sts_t sts;

	rcfe_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd     (cmd),
		.sts     (sts)
	);

	// The datapath holds the configuration, the captured face, the running
	// best distance of the current run and the output register.
	rcfe_dpath #(
		.COORD_BITS  (COORD_BITS),
		.FRAC_BITS   (FRAC_BITS),
		.CELL_ID_BITS(CELL_ID_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.face_dir_x     (face_dir_x),
		.face_dir_y     (face_dir_y),
		.face_dir_z     (face_dir_z),
		.centre_offset_x(centre_offset_x),
		.centre_offset_y(centre_offset_y),
		.centre_offset_z(centre_offset_z),
		.neighbour_id   (neighbour_id),
		.start_bound    (start_bound),
		.current_cell   (current_cell),
		.first_face     (first_face),
		.last_face      (last_face),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.exit_distance  (exit_distance),
		.next_cell      (next_cell),
		.face_found     (face_found)
	);

endmodule

### sim/ray_cell_face_exit_distance_unit_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the ray cell exit unit. Each accepted face
// transaction is run through a software copy of the face tracker (the plane
// distance of the face and the nearest-face bookkeeping over a cell's run),
// and every last face leaves one expected exit in a queue. A checker process
// compares each output transaction with the oldest queued exit, field by
// field. Directed tests cover reset state, the face kinds that are skipped,
// run markers and extreme ray settings. Then a long hold-off on the output
// side fills the block, and finally random cell walks run under several
// idling patterns and ray settings.
module ray_cell_face_exit_distance_unit_test;

	localparam int COORD_W = rcfe_pkg::DEF_COORD_BITS;
	localparam int FRAC_W  = rcfe_pkg::DEF_FRAC_BITS;
	localparam int ID_W    = rcfe_pkg::DEF_CELL_ID_BITS;

	localparam logic [COORD_W-2:0] DIST_MAX = {(COORD_W - 1){1'b1}};
	localparam logic [COORD_W-1:0] ONE      = 32'h0001_0000;
	localparam logic [COORD_W-1:0] MOST_POS = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] MOST_NEG = 32'h8000_0000;
	localparam logic [ID_W-1:0]    ID_MAX   = {ID_W{1'b1}};

	// This margin covers a face that is still in flight when the last
	// expected exit has already arrived.
	localparam int SETTLE_CYCLES = 80;
	localparam int WALK_FACES    = 250;

	typedef struct {
		logic [COORD_W-1:0] face_dir_x;
		logic [COORD_W-1:0] face_dir_y;
		logic [COORD_W-1:0] face_dir_z;
		logic [COORD_W-1:0] centre_offset_x;
		logic [COORD_W-1:0] centre_offset_y;
		logic [COORD_W-1:0] centre_offset_z;
		logic [ID_W-1:0]    neighbour_id;
		logic [COORD_W-2:0] start_bound;
		logic [ID_W-1:0]    current_cell;
		logic               first_face;
		logic               last_face;
	} face_item_t;

	typedef struct {
		logic [COORD_W-2:0] exit_distance;
		logic [ID_W-1:0]    next_cell;
		logic               face_found;
	} cell_exit_t;

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_wr_en;
	logic [rcfe_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [COORD_W-1:0]                  cfg_data;
	logic                                in_valid;
	logic                                in_ready;
	logic [COORD_W-1:0]                  face_dir_x;
	logic [COORD_W-1:0]                  face_dir_y;
	logic [COORD_W-1:0]                  face_dir_z;
	logic [COORD_W-1:0]                  centre_offset_x;
	logic [COORD_W-1:0]                  centre_offset_y;
	logic [COORD_W-1:0]                  centre_offset_z;
	logic [ID_W-1:0]                     neighbour_id;
	logic [COORD_W-2:0]                  start_bound;
	logic [ID_W-1:0]                     current_cell;
	logic                                first_face;
	logic                                last_face;
	logic                                out_valid;
	logic                                out_ready;
	logic [COORD_W-2:0]                  exit_distance;
	logic [ID_W-1:0]                     next_cell;
	logic                                face_found;

	// Shadow of the configuration registers, in their reset state.
	logic [COORD_W-1:0] ray_x      = '0;
	logic [COORD_W-1:0] ray_y      = '0;
	logic [COORD_W-1:0] ray_z      = ONE;
	logic [COORD_W-2:0] dist_floor = '0;

	// Nearest-face tracking state of the cell being walked.
	logic [COORD_W-2:0] near_dist  = '0;
	logic [ID_W-1:0]    near_cell  = '0;
	logic [ID_W-1:0]    leaving_id = '0;
	logic               near_found = 1'b0;

	cell_exit_t exits_due[$];

	int mismatches     = 0;
	int faces_sent     = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_left      = 0;

	ray_cell_face_exit_distance_unit i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.face_dir_x      (face_dir_x),
		.face_dir_y      (face_dir_y),
		.face_dir_z      (face_dir_z),
		.centre_offset_x (centre_offset_x),
		.centre_offset_y (centre_offset_y),
		.centre_offset_z (centre_offset_z),
		.neighbour_id    (neighbour_id),
		.start_bound     (start_bound),
		.current_cell    (current_cell),
		.first_face      (first_face),
		.last_face       (last_face),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.exit_distance   (exit_distance),
		.next_cell       (next_cell),
		.face_found      (face_found)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Tracks one accepted face. The plane distance is worked out exactly in
	// wide signed arithmetic: numerator (2o + d) . d, denominator r . d, and
	// the quotient num * 2^FRAC / (2 * den), truncated and saturated. Faces
	// with a zero denominator, a zero numerator or opposite signs never win.
	function automatic void track_face(input face_item_t f, output bit emits,
			output cell_exit_t res);
		logic signed [127:0] dx, dy, dz, ox, oy, oz, num, den, quot;
		logic [COORD_W-2:0] plane_dist;
		dx = $signed(f.face_dir_x);
		dy = $signed(f.face_dir_y);
		dz = $signed(f.face_dir_z);
		ox = $signed(f.centre_offset_x);
		oy = $signed(f.centre_offset_y);
		oz = $signed(f.centre_offset_z);
		if (f.first_face) begin
			near_dist  = f.start_bound;
			leaving_id = f.current_cell;
			near_found = 1'b0;
		end
		num = (2 * ox + dx) * dx + (2 * oy + dy) * dy + (2 * oz + dz) * dz;
		den = $signed(ray_x) * dx + $signed(ray_y) * dy + $signed(ray_z) * dz;
		if (den != 0 && num != 0 && ((num < 0) == (den < 0))) begin
			if (num < 0) begin
				num = -num;
				den = -den;
			end
			quot = (num <<< FRAC_W) / (den <<< 1);
			plane_dist = (quot > DIST_MAX) ? DIST_MAX : quot[COORD_W-2:0];
			if (plane_dist < near_dist && plane_dist > dist_floor) begin
				near_dist  = plane_dist;
				near_cell  = f.neighbour_id;
				near_found = 1'b1;
			end
		end
		emits             = f.last_face;
		res.exit_distance = near_dist;
		res.next_cell     = near_found ? near_cell : leaving_id;
		res.face_found    = near_found;
	endfunction

	function automatic face_item_t face_of(input logic [COORD_W-1:0] dx, dy, dz,
			input logic [COORD_W-1:0] ox, oy, oz, input logic [ID_W-1:0] id,
			input logic [COORD_W-2:0] bound, input logic [ID_W-1:0] cell_id,
			input bit first, input bit last);
		face_item_t f;
		f.face_dir_x      = dx;
		f.face_dir_y      = dy;
		f.face_dir_z      = dz;
		f.centre_offset_x = ox;
		f.centre_offset_y = oy;
		f.centre_offset_z = oz;
		f.neighbour_id    = id;
		f.start_bound     = bound;
		f.current_cell    = cell_id;
		f.first_face      = first;
		f.last_face       = last;
		return f;
	endfunction

	function automatic logic [COORD_W-1:0] rand_span(input int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	// Mostly generous bounds, some tight ones, and
	// some fully random ones.
	function automatic logic [COORD_W-2:0] pick_bound();
		int roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return (COORD_W - 1)'($urandom_range(DIST_MAX, 1 << 20));
		else if (roll < 80)
			return (COORD_W - 1)'($urandom_range(1 << 18));
		return (COORD_W - 1)'($urandom);
	endfunction

	// A face of a plausible cell: short vectors in model units, so that the
	// plane distances land in the range where bounds and the cutoff matter.
	function automatic face_item_t geo_face();
		face_item_t f;
		int span;
		int roll;
		span = ($urandom_range(9) == 0) ? (1 << 24) : (1 << 18);
		roll = $urandom_range(99);
		f = face_of(rand_span(span), rand_span(span), rand_span(span),
			rand_span(span / 2), rand_span(span / 2), rand_span(span / 2),
			ID_W'($urandom), pick_bound(), ID_W'($urandom), 1'b0, 1'b0);
		// Faces parallel to an axis-aligned ray, and degenerate faces.
		if (roll < 5)
			f.face_dir_z = '0;
		else if (roll < 8) begin
			f.face_dir_x = '0;
			f.face_dir_y = '0;
			f.face_dir_z = '0;
		end
		return f;
	endfunction

	function automatic face_item_t noise_face();
		return face_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			ID_W'($urandom), (COORD_W - 1)'($urandom), ID_W'($urandom),
			1'($urandom_range(1)), 1'($urandom_range(1)));
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: mismatch in %s: got %0h, want %0h", $time, what, got, want);
		mismatches++;
	endtask

	// Offers one face transaction. The payload changes only at a falling
	// edge, and valid stays high from one face to the next unless the sender
	// decides to idle.
	task automatic offer_face(input face_item_t f);
		bit emits;
		cell_exit_t res;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		face_dir_x      <= f.face_dir_x;
		face_dir_y      <= f.face_dir_y;
		face_dir_z      <= f.face_dir_z;
		centre_offset_x <= f.centre_offset_x;
		centre_offset_y <= f.centre_offset_y;
		centre_offset_z <= f.centre_offset_z;
		neighbour_id    <= f.neighbour_id;
		start_bound     <= f.start_bound;
		current_cell    <= f.current_cell;
		first_face      <= f.first_face;
		last_face       <= f.last_face;
		in_valid        <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		track_face(f, emits, res);
		if (emits)
			exits_due.push_back(res);
		faces_sent++;
	endtask

	// Stops offering, waits for every expected exit, then lets a face that
	// produces no exit finish. The task returns just after a rising edge.
	task automatic drain_exits();
		@(negedge clk);
		in_valid <= 1'b0;
		while (exits_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rcfe_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [COORD_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			rcfe_pkg::REG_RAY_DIR_X: begin
				ray_x = data;
			end
			rcfe_pkg::REG_RAY_DIR_Y: begin
				ray_y = data;
			end
			rcfe_pkg::REG_RAY_DIR_Z: begin
				ray_z = data;
			end
			rcfe_pkg::REG_MIN_DISTANCE: begin
				dist_floor = data[COORD_W-2:0];
			end
			default: begin
			end
		endcase
	endtask

	// Writes all four registers back to back. The top bit of the cutoff word
	// lies outside the register and must be dropped by the block.
	task automatic program_ray(input logic [COORD_W-1:0] rx, ry, rz,
			input logic [COORD_W-1:0] floor_word);
		write_reg(rcfe_pkg::REG_RAY_DIR_X, rx);
		write_reg(rcfe_pkg::REG_RAY_DIR_Y, ry);
		write_reg(rcfe_pkg::REG_RAY_DIR_Z, rz);
		write_reg(rcfe_pkg::REG_MIN_DISTANCE, floor_word);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Straight after reset the bound is zero, so a face that arrives without
	// a first face cannot qualify and the exit falls back to cell zero. The
	// ray register still holds its reset value of one unit along z.
	task automatic test_reset_state();
		offer_face(face_of(0, 0, 2 * ONE, 0, 0, 0, 16'h0101, DIST_MAX, 16'h0202,
			1'b0, 1'b1));
		offer_face(face_of(0, 0, 2 * ONE, 0, 0, 0, 16'h0303, DIST_MAX, 16'h0404,
			1'b1, 1'b1));
		drain_exits();
	endtask

	// One run that walks through every kind of face the distance logic
	// treats specially, then a single-face run in which nothing qualifies.
	task automatic test_special_faces();
		// Face parallel to the ray: zero denominator.
		offer_face(face_of(ONE, 0, 0, 0, 0, 0, 16'h0011, DIST_MAX, 16'h0007,
			1'b1, 1'b0));
		// Plane behind the ray: negative distance.
		offer_face(face_of(0, 0, -2 * ONE, 0, 0, 0, 16'h0012, 0, 0, 1'b0, 1'b0));
		// Ray starts on the plane: zero numerator.
		offer_face(face_of(0, 0, 2 * ONE, 0, 0, -ONE, 16'h0013, 0, 0, 1'b0, 1'b0));
		// Far plane: the quotient saturates and so never beats a bound.
		offer_face(face_of(0, 0, 1 << 20, 0, 0, MOST_POS, 16'h0014, 0, 0,
			1'b0, 1'b0));
		offer_face(face_of(0, 0, 2 * ONE, 0, 0, 0, ID_MAX, 0, 0, 1'b0, 1'b0));
		offer_face(face_of(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG,
			MOST_NEG, 0, 0, 0, 1'b0, 1'b0));
		offer_face(face_of(MOST_POS, MOST_POS, MOST_POS, MOST_POS, MOST_POS,
			MOST_POS, 16'h0017, 0, 0, 1'b0, 1'b1));
		offer_face(face_of(ONE, ONE, 0, ONE, 0, 0, 16'h0018, DIST_MAX, ID_MAX,
			1'b1, 1'b1));
		drain_exits();
	endtask

	// The last face leaves the tracking state alone, so a face without a
	// first face is measured against the previous run's winner. A zero
	// start bound rejects every face of a run.
	task automatic test_run_markers();
		offer_face(face_of(0, 0, 4 * ONE, 0, 0, 0, 16'h1234, DIST_MAX, 16'h0001,
			1'b1, 1'b1));
		offer_face(face_of(0, 0, 2 * ONE, 0, 0, 0, 16'h0042, 0, 16'h0002,
			1'b0, 1'b1));
		offer_face(face_of(0, 0, 2 * ONE, 0, 0, 0, 16'h0043, 0, 16'h0003,
			1'b1, 1'b0));
		offer_face(face_of(0, 0, 2 * ONE, 0, 0, 0, 16'h0044, DIST_MAX, 16'h0004,
			1'b0, 1'b1));
		drain_exits();
	endtask

	// Ray components and the cutoff at the ends of their ranges. With the
	// largest cutoff no face can qualify.
	task automatic test_config_extremes();
		face_item_t f;
		program_ray(MOST_NEG, MOST_POS, 0, {1'b0, DIST_MAX});
		f = geo_face();
		f.first_face = 1'b1;
		f.last_face  = 1'b1;
		offer_face(f);
		offer_face(face_of(MOST_POS, MOST_NEG, ONE, MOST_NEG, MOST_POS, 0,
			16'h00AA, DIST_MAX, 16'h00BB, 1'b1, 1'b1));
		drain_exits();
		program_ray(MOST_POS, MOST_NEG, MOST_POS, {1'b1, {(COORD_W - 1){1'b0}}});
		f = geo_face();
		f.first_face = 1'b1;
		f.last_face  = 1'b1;
		offer_face(f);
		offer_face(face_of(ONE, -ONE, ONE, 0, 0, 0, 16'h00CC, DIST_MAX, 16'h00DD,
			1'b1, 1'b1));
		drain_exits();
	endtask

	// The receiver holds off for a long stretch while single-face runs keep
	// coming. The block parks one exit in its output register, finishes a
	// second one, and must then hold its input until the receiver returns.
	task automatic test_output_hold_off();
		face_item_t f;
		int k;
		program_ray(rand_span(1 << 16), rand_span(1 << 16), ONE, 0);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = 1500;
		for (k = 0; k < 30; k++) begin
			f = geo_face();
			f.first_face = 1'b1;
			f.last_face  = 1'b1;
			offer_face(f);
		end
		drain_exits();
	endtask

	// One cell's run of faces. Now and then a run loses its first or its last
	// marker, and a few faces inside a run carry arbitrary values.
	task automatic send_cell_run();
		face_item_t f;
		int n;
		int k;
		bit drop_first;
		bit drop_last;
		n          = $urandom_range(8, 1);
		drop_first = ($urandom_range(99) < 5);
		drop_last  = ($urandom_range(99) < 5);
		for (k = 0; k < n; k++) begin
			f = ($urandom_range(99) < 10) ? noise_face() : geo_face();
			f.first_face = (k == 0) && !drop_first;
			f.last_face  = (k == n - 1) && !drop_last;
			offer_face(f);
		end
	endtask

	// Random walks in eight phases: each idling pattern meets two ray
	// settings. Between runs the sender sometimes waits for every exit.
	task automatic test_random_walks();
		int send_pcts[4] = '{0, 84, 0, 14};
		int recv_pcts[4] = '{0, 0, 84, 14};
		int phase;
		int goal;
		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: program_ray(0, 0, ONE, 0);
				1: program_ray(rand_span(1 << 16), rand_span(1 << 16), rand_span(1 << 16),
					{1'($urandom_range(1)), 15'd0, 16'($urandom)});
				2: program_ray(MOST_POS, MOST_NEG, MOST_POS, 0);
				default: program_ray($urandom, $urandom, $urandom, 0);
			endcase
			send_idle_pct  = send_pcts[phase / 2];
			recv_stall_pct = recv_pcts[phase / 2];
			goal = faces_sent + WALK_FACES;
			while (faces_sent < goal) begin
				if ($urandom_range(99) < 4)
					offer_face(noise_face());
				else
					send_cell_run();
				if ($urandom_range(99) < 2)
					drain_exits();
			end
			drain_exits();
		end
	endtask

	// Receiver side: ready changes only at the falling edge. A hold-off that
	// a test requests is counted down here, cycle by cycle.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Every output transaction is matched against the oldest queued exit.
	always @(posedge clk) begin : exit_check
		cell_exit_t want;
		if (arst_n && out_valid && out_ready) begin
			if (exits_due.size() == 0) begin
				flag_mismatch("unexpected exit", 64'(exit_distance), 64'(0));
			end else begin
				want = exits_due.pop_front();
				if (exit_distance !== want.exit_distance)
					flag_mismatch("exit_distance", 64'(exit_distance),
						64'(want.exit_distance));
				if (next_cell !== want.next_cell)
					flag_mismatch("next_cell", 64'(next_cell), 64'(want.next_cell));
				if (face_found !== want.face_found)
					flag_mismatch("face_found", 64'(face_found), 64'(want.face_found));
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		in_valid        = 1'b0;
		face_dir_x      = '0;
		face_dir_y      = '0;
		face_dir_z      = '0;
		centre_offset_x = '0;
		centre_offset_y = '0;
		centre_offset_z = '0;
		neighbour_id    = '0;
		start_bound     = '0;
		current_cell    = '0;
		first_face      = 1'b0;
		last_face       = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_special_faces();
		test_run_markers();
		test_config_extremes();
		test_output_hold_off();
		test_random_walks();
		drain_exits();

		if (mismatches == 0) begin
			$display("** ray_cell_face_exit_distance_unit: PASSED **");
		end else begin
			$display("** ray_cell_face_exit_distance_unit: FAILED **");
		end
		$finish;
	end

	// A correct run takes a few milliseconds of simulated time at most.
	initial begin
		#20_000_000;
		$display("** ray_cell_face_exit_distance_unit: FAILED **");
		$finish;
	end

endmodule
